>>> design/scch_pkg.sv
// ----------------------------------------------------------------------------
// Space curve cluster halftoner package
// Shared widths, register indexes, command codes and types.
// ----------------------------------------------------------------------------
package scch_pkg;

    localparam int GRAY_W     = 8;
    localparam int SIZE_W     = 6;
    localparam int THR_W      = 13;
    localparam int RESP_W     = 14;
    localparam int IDX_W      = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FULL_BLACK = 255;

    localparam logic [IDX_W-1:0] REG_MAX_SIZE = 2'd0;
    localparam logic [IDX_W-1:0] REG_EDGE_THR = 2'd1;
    localparam logic [IDX_W-1:0] REG_PRECIP   = 2'd2;
    localparam logic [IDX_W-1:0] REG_CLUST    = 2'd3;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_DEC = 2'd1;
    localparam logic [1:0] OP_END = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0] max_size;
        logic [THR_W-1:0]  edge_thr;
        logic              precip_en;
        logic              clust_en;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        op;
        logic [GRAY_W-1:0] gray;
        logic              edge_hit;
        logic              item_last;
    } t_cmd;

endpackage

>>> design/scch_if.sv
// ----------------------------------------------------------------------------
// Space curve cluster halftoner channels
// Pixel input, dot output and configuration write channels.
// ----------------------------------------------------------------------------
interface scch_pix_if import scch_pkg::*;;
    logic              valid;
    logic              ready;
    logic [GRAY_W-1:0] gray;
    logic              last_pixel;
    modport source (output valid, gray, last_pixel, input ready);
    modport sink   (input valid, gray, last_pixel, output ready);
endinterface

interface scch_dot_if;
    logic valid;
    logic ready;
    logic dot;
    logic run_end;
    logic image_end;
    modport source (output valid, dot, run_end, image_end, input ready);
    modport sink   (input valid, dot, run_end, image_end, output ready);
endinterface

interface scch_cfg_if import scch_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [IDX_W-1:0]      index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/scch_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Four-entry queue between the pixel front end and the cluster engine.
// ----------------------------------------------------------------------------
module scch_fifo import scch_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);
    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [PTR_W:0]   r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_ready = (r_cnt != (PTR_W+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

>>> design/scch_front.sv
// ----------------------------------------------------------------------------
// Pixel front end
// Keeps the pixel window, runs the edge filter and issues cluster commands.
// ----------------------------------------------------------------------------
module scch_front import scch_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    scch_pix_if.sink     i_pix,
    input  t_cfg         i_cfg,
    output t_cmd         o_cmd,
    output logic         o_cmd_valid,
    input  logic         i_cmd_ready
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAIN = 2'd1;
    localparam logic [1:0] ST_TAIL = 2'd2;
    localparam logic [1:0] ST_END  = 2'd3;

    logic [GRAY_W-1:0]        r_win [7];
    logic signed [RESP_W-1:0] r_prev;
    logic [2:0]               r_s;
    logic [2:0]               r_s_old;
    logic                     r_last;
    logic [1:0]               r_state;
    logic [1:0]               r_d;

    logic [1:0]               d_sel;
    logic [GRAY_W-1:0]        v0, v1, v3, v5, v6, pix;
    logic signed [RESP_W-1:0] resp;
    logic signed [RESP_W-1:0] prev;
    logic signed [RESP_W:0]   diff;
    logic [RESP_W:0]          mag;
    logic                     first;
    logic                     zero_cross;
    logic                     edge_hit;
    logic                     adv;

    function automatic logic signed [RESP_W-1:0] log_response(
        input logic [GRAY_W-1:0] a0, input logic [GRAY_W-1:0] a1,
        input logic [GRAY_W-1:0] a3, input logic [GRAY_W-1:0] a5,
        input logic [GRAY_W-1:0] a6);
        logic signed [RESP_W-1:0] e0, e1, e3, e5, e6;
        e0 = {{(RESP_W-GRAY_W){1'b0}}, a0};
        e1 = {{(RESP_W-GRAY_W){1'b0}}, a1};
        e3 = {{(RESP_W-GRAY_W){1'b0}}, a3};
        e5 = {{(RESP_W-GRAY_W){1'b0}}, a5};
        e6 = {{(RESP_W-GRAY_W){1'b0}}, a6};
        return (e3 <<< 3) + (e3 <<< 2) + e3 - e0 - e6
               - ((e1 <<< 2) + e1) - ((e5 <<< 2) + e5);
    endfunction

    assign i_pix.ready = (r_state == ST_IDLE);
    assign d_sel = (r_state == ST_MAIN) ? 2'd3 : r_d;

    always_comb begin
        case (d_sel)
            2'd3: begin
                v0 = r_win[0]; v1 = r_win[1]; v3 = r_win[3];
                v5 = r_win[5]; v6 = r_win[6]; pix = r_win[3];
            end
            2'd2: begin
                v0 = r_win[1]; v1 = r_win[2]; v3 = r_win[4];
                v5 = r_win[6]; v6 = r_win[6]; pix = r_win[4];
            end
            2'd1: begin
                v0 = r_win[2]; v1 = r_win[3]; v3 = r_win[5];
                v5 = r_win[6]; v6 = r_win[6]; pix = r_win[5];
            end
            default: begin
                v0 = r_win[3]; v1 = r_win[4]; v3 = r_win[6];
                v5 = r_win[6]; v6 = r_win[6]; pix = r_win[6];
            end
        endcase
    end

    always_comb begin
        resp  = log_response(v0, v1, v3, v5, v6);
        first = (r_s_old != 3'd7) && (r_s_old == 3'd3 + 3'(d_sel));
        prev  = first ? resp : r_prev;
        diff  = {resp[RESP_W-1], resp} - {prev[RESP_W-1], prev};
        mag   = (diff < 0) ? -diff : diff;
        zero_cross = (!resp[RESP_W-1] && (prev[RESP_W-1] || prev == '0))
                  || ((resp[RESP_W-1] || resp == '0) && !prev[RESP_W-1]);
        edge_hit = i_cfg.clust_en && zero_cross
                && (mag > (RESP_W+1)'(i_cfg.edge_thr));
    end

    always_comb begin
        o_cmd_valid     = 1'b0;
        o_cmd.op        = OP_DEC;
        o_cmd.gray      = pix;
        o_cmd.edge_hit  = edge_hit;
        o_cmd.item_last = 1'b0;
        case (r_state)
            ST_MAIN: begin
                o_cmd.item_last = !r_last;
                if (r_s_old < 3'd3) begin
                    o_cmd_valid = 1'b1;
                    o_cmd.op    = OP_ADD;
                    o_cmd.gray  = r_win[6];
                end else if (r_s_old >= 3'd6) begin
                    o_cmd_valid = 1'b1;
                end
            end
            ST_TAIL: begin
                o_cmd_valid = 1'b1;
            end
            ST_END: begin
                o_cmd_valid     = 1'b1;
                o_cmd.op        = OP_END;
                o_cmd.item_last = 1'b1;
            end
            default: begin
                o_cmd_valid = 1'b0;
            end
        endcase
    end

    assign adv = !o_cmd_valid || i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_s     <= '0;
            r_prev  <= '0;
            r_d     <= '0;
            r_last  <= 1'b0;
            r_s_old <= '0;
            for (int k = 0; k < 7; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_pix.valid) begin
                        for (int k = 0; k < 6; k++) begin
                            r_win[k] <= r_win[k+1];
                        end
                        r_win[6] <= i_pix.gray;
                        r_s      <= (r_s == 3'd7) ? 3'd7 : r_s + 3'd1;
                        r_s_old  <= r_s;
                        r_last   <= i_pix.last_pixel;
                        r_state  <= ST_MAIN;
                    end
                end
                ST_MAIN: begin
                    if (adv) begin
                        if (o_cmd_valid && o_cmd.op == OP_DEC) begin
                            r_prev <= resp;
                        end
                        if (!r_last) begin
                            r_state <= ST_IDLE;
                        end else if (r_s_old >= 3'd3) begin
                            r_d     <= (r_s_old >= 3'd5) ? 2'd2 : 2'(r_s_old - 3'd3);
                            r_state <= ST_TAIL;
                        end else begin
                            r_state <= ST_END;
                        end
                    end
                end
                ST_TAIL: begin
                    if (adv) begin
                        r_prev <= resp;
                        if (r_d == 2'd0) begin
                            r_state <= ST_END;
                        end else begin
                            r_d <= r_d - 2'd1;
                        end
                    end
                end
                default: begin
                    if (adv) begin
                        for (int k = 0; k < 7; k++) begin
                            r_win[k] <= '0;
                        end
                        r_prev  <= '0;
                        r_s     <= '0;
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end
endmodule

>>> design/scch_back.sv
// ----------------------------------------------------------------------------
// Cluster engine
// Stores the cluster, finds the densest window (if precip_en), emits the dots.
// ----------------------------------------------------------------------------
module scch_back import scch_pkg::*; #(
    parameter int MAX_CLUSTER = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_cmd       i_cmd,
    input  logic       i_cmd_valid,
    output logic       o_cmd_ready,
    scch_dot_if.source o_dot
);
    localparam int CNT_W = $clog2(MAX_CLUSTER + 1);
    localparam int ADR_W = $clog2(MAX_CLUSTER);
    localparam int TOT_W = $clog2(MAX_CLUSTER * FULL_BLACK + FULL_BLACK);
    localparam int SUM_W = $clog2(MAX_CLUSTER * FULL_BLACK + 1);
    localparam int LIM_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
    localparam int QW    = TOT_W + 1;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_ADD  = 3'd1;
    localparam logic [2:0] B_FLEN = 3'd2;
    localparam logic [2:0] B_SCAN = 3'd3;
    localparam logic [2:0] B_EMIT = 3'd4;
    localparam logic [2:0] B_DONE = 3'd5;

    logic [GRAY_W-1:0] r_mem [MAX_CLUSTER];
    logic [GRAY_W-1:0] r_rda;
    logic [GRAY_W-1:0] r_rdb;
    logic [2:0]        r_state;
    logic [2:0]        r_ret;
    t_cmd              r_cmd;
    logic [CNT_W-1:0]  r_cnt;
    logic [TOT_W-1:0]  r_tot;
    logic [CNT_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_start;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_best;
    logic [CNT_W-1:0]  r_ia;
    logic              r_pv;
    logic [CNT_W-1:0]  r_pi;
    logic [CNT_W-1:0]  r_e;
    logic              r_held_v;
    logic              r_held_dot;
    logic              r_ov;
    logic              r_odot;
    logic              r_orun;
    logic              r_oend;

    logic [LIM_W-1:0]  lim;
    logic              cnt_ge;
    logic              cnt_ge_next;
    logic [QW-1:0]     q;
    logic [QW-1:0]     q8;
    logic [CNT_W-1:0]  len;
    logic [ADR_W-1:0]  ra;
    logic [ADR_W-1:0]  rb;
    logic              w_en;
    logic [SUM_W-1:0]  s_nxt;
    logic              out_free;
    logic              ov_load;
    logic              dot;

    assign lim = (LIM_W'(i_cfg.max_size) > LIM_W'(MAX_CLUSTER))
               ? LIM_W'(MAX_CLUSTER) : LIM_W'(i_cfg.max_size);
    assign cnt_ge      = LIM_W'(r_cnt) >= lim;
    assign cnt_ge_next = (LIM_W'(r_cnt) + LIM_W'(1)) >= lim;

    assign q   = QW'(r_tot) + QW'(1) + QW'(r_tot >> 8);
    assign q8  = q >> 8;
    assign len = (q8 > QW'(r_cnt)) ? r_cnt : CNT_W'(q8);

    assign ra   = r_ia[ADR_W-1:0];
    assign rb   = ADR_W'(r_ia - r_len);
    assign w_en = (r_state == B_ADD) && (r_cnt < CNT_W'(MAX_CLUSTER));

    assign s_nxt = (r_pi < r_len) ? r_sum + SUM_W'(r_rda)
                                  : r_sum + SUM_W'(r_rda) - SUM_W'(r_rdb);

    assign out_free = !r_ov || o_dot.ready;
    assign ov_load  = r_held_v && out_free
                   && (((r_state == B_EMIT) && (r_e != r_cnt))
                    || ((r_state == B_DONE) && r_cmd.item_last));
    assign dot = (r_tot >= TOT_W'(FULL_BLACK)) && (r_e >= r_start);

    assign o_cmd_ready     = (r_state == B_IDLE);
    assign o_dot.valid     = r_ov;
    assign o_dot.dot       = r_odot;
    assign o_dot.run_end   = r_orun;
    assign o_dot.image_end = r_oend;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[r_cnt[ADR_W-1:0]] <= r_cmd.gray;
        end
        r_rda <= r_mem[ra];
        r_rdb <= r_mem[rb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ret    <= B_DONE;
            r_cnt    <= '0;
            r_tot    <= '0;
            r_pv     <= 1'b0;
            r_held_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (ov_load) begin
                r_ov <= 1'b1;
            end else if (o_dot.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        case (i_cmd.op)
                            OP_ADD: begin
                                r_state <= B_ADD;
                            end
                            OP_DEC: begin
                                r_ret   <= B_ADD;
                                r_state <= (i_cmd.edge_hit || cnt_ge) ? B_FLEN : B_ADD;
                            end
                            default: begin
                                r_ret   <= B_DONE;
                                r_state <= B_FLEN;
                            end
                        endcase
                    end
                end
                B_ADD: begin
                    if (w_en) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_tot <= r_tot + TOT_W'(r_cmd.gray);
                    end
                    r_ret <= B_DONE;
                    if (r_cmd.op == OP_DEC && cnt_ge_next) begin
                        r_state <= B_FLEN;
                    end else begin
                        r_state <= B_DONE;
                    end
                end
                B_FLEN: begin
                    r_len   <= len;
                    r_start <= '0;
                    r_sum   <= '0;
                    r_best  <= '0;
                    r_ia    <= '0;
                    r_e     <= '0;
                    r_pv    <= 1'b0;
                    if (r_cnt == '0) begin
                        r_state <= r_ret;
                    end else if (i_cfg.precip_en) begin
                        r_state <= B_SCAN;
                    end else begin
                        r_state <= B_EMIT;
                    end
                end
                B_SCAN: begin
                    r_pv <= (r_ia < r_cnt);
                    if (r_ia < r_cnt) begin
                        r_ia <= r_ia + 1'b1;
                        r_pi <= r_ia;
                    end
                    if (r_pv) begin
                        r_sum <= s_nxt;
                        if (r_pi < r_len) begin
                            if (r_pi == r_len - 1'b1) begin
                                r_best <= s_nxt;
                            end
                        end else if (s_nxt > r_best) begin
                            r_best  <= s_nxt;
                            r_start <= r_pi - r_len + 1'b1;
                        end
                    end
                    if (r_ia >= r_cnt && !r_pv) begin
                        r_state <= B_EMIT;
                    end
                end
                B_EMIT: begin
                    if (r_e == r_cnt) begin
                        r_cnt   <= '0;
                        r_state <= r_ret;
                    end else if (!r_held_v || out_free) begin
                        if (dot) begin
                            r_tot <= r_tot - TOT_W'(FULL_BLACK);
                        end
                        if (r_held_v) begin
                            r_odot <= r_held_dot;
                            r_orun <= 1'b0;
                            r_oend <= 1'b0;
                        end
                        r_held_v   <= 1'b1;
                        r_held_dot <= dot;
                        r_e        <= r_e + 1'b1;
                    end
                end
                B_DONE: begin
                    if (!(r_cmd.item_last && r_held_v)) begin
                        if (r_cmd.op == OP_END) begin
                            r_tot <= '0;
                        end
                        r_state <= B_IDLE;
                    end else if (out_free) begin
                        r_odot   <= r_held_dot;
                        r_orun   <= 1'b1;
                        r_oend   <= (r_cmd.op == OP_END);
                        r_held_v <= 1'b0;
                        if (r_cmd.op == OP_END) begin
                            r_tot <= '0;
                        end
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end
endmodule

>>> design/space_curve_cluster_halftoner_top.sv
// ----------------------------------------------------------------------------
// Space curve cluster halftoner
// Turns gray pixels in curve order into black and white dots.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix takes one gray pixel per item, last_pixel on the final pixel of an
//   image. o_dot gives one dot per pixel in curve order; run_end marks the
//   last dot released by an input item, image_end the final dot of an image.
//   i_cfg writes max_cluster_size, edge_threshold, precipitation_enable and
//   clustering_enable (index 0..3); write only while the block is idle.
// Timing:
//   The front end takes a new pixel only when done with the last one. At
//   each flush the cluster engine searches the window if precipitation is
//   enabled (one memory read per cycle), then emits the dots (one dot per
//   cycle while the output is not stalled). A pixel's dots come out when its
//   cluster flushes, at least three pixels later or at the image end.
// Reset: clears the pixel window, the cluster and the gray total; the
//   registers return to 16, 128, 1, 1. No clearing pass is needed.
// Stall: a held output dot stops the cluster engine; the four-entry command
//   queue then fills and the pixel input drops ready.
// ----------------------------------------------------------------------------
module space_curve_cluster_halftoner_top import scch_pkg::*; #(
    parameter int MAX_CLUSTER = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scch_pix_if.sink   i_pix,
    scch_cfg_if.sink   i_cfg,
    scch_dot_if.source o_dot
);
    t_cfg r_cfg;
    t_cmd fr_cmd;
    logic fr_valid;
    logic q_ready;
    t_cmd q_cmd;
    logic q_valid;
    logic bk_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_size  <= SIZE_W'(16);
            r_cfg.edge_thr  <= THR_W'(128);
            r_cfg.precip_en <= 1'b1;
            r_cfg.clust_en  <= 1'b1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MAX_SIZE: r_cfg.max_size  <= i_cfg.data[SIZE_W-1:0];
                REG_EDGE_THR: r_cfg.edge_thr  <= i_cfg.data[THR_W-1:0];
                REG_PRECIP:   r_cfg.precip_en <= i_cfg.data[0];
                REG_CLUST:    r_cfg.clust_en  <= i_cfg.data[0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    scch_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_cfg       (r_cfg),
        .o_cmd       (fr_cmd),
        .o_cmd_valid (fr_valid),
        .i_cmd_ready (q_ready)
    );

    scch_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_data  (fr_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (bk_ready)
    );

    scch_back #(.MAX_CLUSTER(MAX_CLUSTER)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (q_cmd),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (bk_ready),
        .o_dot       (o_dot)
    );
endmodule

>>> design/scch_checker.sv
// ----------------------------------------------------------------------------
// Space curve cluster halftoner checker
// Port-level checks, bound to the top level.
// ----------------------------------------------------------------------------
module scch_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_pix_valid,
    input logic i_pix_ready,
    input logic i_pix_last,
    input logic i_dot_valid,
    input logic i_dot_ready,
    input logic i_dot,
    input logic i_run_end,
    input logic i_image_end
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dot_valid && !i_dot_ready |=> i_dot_valid && $stable(i_dot)
        && $stable(i_run_end) && $stable(i_image_end))
        else $error("dot changed while stalled");

    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dot_valid && i_image_end |-> i_run_end)
        else $error("image end without run end");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_dot_valid)
        else $error("dot valid after reset");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && i_pix_ready && i_pix_last |=> !i_pix_ready)
        else $error("pixel taken during image end");
endmodule

bind space_curve_cluster_halftoner_top scch_checker u_scch_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pix_valid (i_pix.valid),
    .i_pix_ready (i_pix.ready),
    .i_pix_last  (i_pix.last_pixel),
    .i_dot_valid (o_dot.valid),
    .i_dot_ready (o_dot.ready),
    .i_dot       (o_dot.dot),
    .i_run_end   (o_dot.run_end),
    .i_image_end (o_dot.image_end)
);

>>> sim/space_curve_cluster_halftoner_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Space curve cluster halftoner testbench
// Directed images, then random images under several register settings.
// Every dot is checked against a halftone predictor kept in the bench, or a
// fixed one for typed rows, with random input gaps and random output stalls.
// ----------------------------------------------------------------------------
module space_curve_cluster_halftoner_top_test;
    import scch_pkg::*;

    localparam int CLUSTER_CAP  = 32;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct packed {
        logic dot;
        logic run_end;
        logic image_end;
    } t_dot;

    typedef struct {
        logic [7:0] gray;
        bit         last;
        bit         typed;
        bit         dot;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    bit   quiet;
    int   cycles;
    int   mismatches;
    int   pixels_sent;
    int   images_sent;
    int   dots_seen;
    int   phases_run;

    scch_pix_if pix ();
    scch_cfg_if cfg ();
    scch_dot_if dots ();

    space_curve_cluster_halftoner_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .i_cfg   (cfg),
        .o_dot   (dots)
    );

    // halftone predictor state
    int   ht_size, ht_thr, ht_precip, ht_clust;
    int   ht_window [7];
    int   ht_prev;
    int   ht_store [CLUSTER_CAP];
    int   ht_count, ht_total, ht_seen;
    t_dot pending_dots [$];

    const int lap_taps [7] = '{-1, -5, 0, 13, 0, -5, -1};

    const t_row dir_rows [22] = '{
        '{8'd255, 1, 1, 1}, '{8'd0, 1, 1, 0}, '{8'd128, 1, 1, 0},
        '{8'd255, 0, 0, 0}, '{8'd0, 0, 0, 0}, '{8'd255, 1, 0, 0},
        '{8'd0, 0, 0, 0}, '{8'd255, 0, 0, 0}, '{8'd0, 0, 0, 0}, '{8'd255, 0, 0, 0},
        '{8'd0, 0, 0, 0}, '{8'd0, 0, 0, 0}, '{8'd255, 0, 0, 0}, '{8'd255, 0, 0, 0},
        '{8'd255, 0, 0, 0}, '{8'd0, 1, 0, 0},
        '{8'd100, 0, 0, 0}, '{8'd100, 0, 0, 0}, '{8'd100, 0, 0, 0},
        '{8'd100, 0, 0, 0}, '{8'd100, 0, 0, 0}, '{8'd255, 1, 0, 0}
    };

    function automatic void ht_reset_image();
        foreach (ht_window[i]) ht_window[i] = 0;
        ht_prev  = 0;
        ht_count = 0;
        ht_total = 0;
        ht_seen  = 0;
    endfunction

    function automatic int cluster_limit();
        return (ht_size > CLUSTER_CAP) ? CLUSTER_CAP : ht_size;
    endfunction

    function automatic void ht_join(int g);
        if (ht_count < CLUSTER_CAP) begin
            ht_store[ht_count] = g;
            ht_count++;
            ht_total += g;
        end
    endfunction

    function automatic void ht_flush(ref bit out [$]);
        int start, len, sum, best;
        start = 0;
        if (ht_precip != 0) begin
            len = ht_total / FULL_BLACK;
            if (len > ht_count) len = ht_count;
            sum = 0;
            for (int i = 0; i < len; i++) sum += ht_store[i];
            best = sum;
            for (int i = len; i < ht_count; i++) begin
                sum = sum + ht_store[i] - ht_store[i - len];
                if (sum > best) begin
                    best  = sum;
                    start = i - len + 1;
                end
            end
        end
        for (int i = 0; i < ht_count; i++) begin
            if (ht_total >= FULL_BLACK && i >= start) begin
                ht_total -= FULL_BLACK;
                out.push_back(1'b1);
            end else begin
                out.push_back(1'b0);
            end
        end
        ht_count = 0;
    endfunction

    function automatic int log_response(int d);
        int acc, pos;
        acc = 0;
        for (int i = 0; i < 7; i++) begin
            pos = 3 - d + i;
            if (pos > 6) pos = 6;
            acc += lap_taps[i] * ht_window[pos];
        end
        return acc;
    endfunction

    function automatic void ht_decide(int d, bit first, ref bit out [$]);
        int  r, jump;
        bit  hit;
        r = log_response(d);
        if (first) ht_prev = r;
        jump = r - ht_prev;
        if (jump < 0) jump = -jump;
        hit = (ht_clust != 0) && ((r >= 0 && ht_prev <= 0) || (r <= 0 && ht_prev >= 0))
              && (jump > ht_thr);
        ht_prev = r;
        if (hit || ht_count >= cluster_limit()) ht_flush(out);
        ht_join(ht_window[6 - d]);
        if (ht_count >= cluster_limit()) ht_flush(out);
    endfunction

    function automatic void halftone_pixel(int g, bit last, ref t_dot res [$]);
        bit out [$];
        int s, dmax;
        t_dot item;
        s = ht_seen;
        for (int i = 0; i < 6; i++) ht_window[i] = ht_window[i + 1];
        ht_window[6] = g;
        ht_seen = (s < 7) ? s + 1 : 7;
        if (s < 3) ht_join(g);
        else if (s >= 6) ht_decide(3, s == 6, out);
        if (last) begin
            if (s >= 3) begin
                dmax = (s >= 5) ? 2 : s - 3;
                for (int d = dmax; d >= 0; d--) ht_decide(d, (s < 7) && (s - d == 3), out);
            end
            ht_flush(out);
            ht_reset_image();
        end
        foreach (out[i]) begin
            item.dot       = out[i];
            item.run_end   = (i == out.size() - 1);
            item.image_end = last && (i == out.size() - 1);
            res.push_back(item);
        end
    endfunction

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d dots pending", cycles, pending_dots.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) dots.ready = 1'b0;
        else dots.ready = quiet || ($urandom_range(99) >= 14);
    end

    always @(posedge i_clk) begin
        t_dot want, got;
        if (i_rst_n && dots.valid && dots.ready) begin
            dots_seen++;
            got = '{dots.dot, dots.run_end, dots.image_end};
            if (pending_dots.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected dot %b/%b/%b", got.dot,
                                               got.run_end, got.image_end);
            end else begin
                want = pending_dots.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("dot %0d: expected dot/run/image %b/%b/%b, got %b/%b/%b",
                                 dots_seen, want.dot, want.run_end, want.image_end,
                                 got.dot, got.run_end, got.image_end);
                end
            end
        end
    end

    task automatic send_pixel(input logic [7:0] g, input bit last, input bit typed,
                              input bit tdot);
        t_dot res [$];
        while (!quiet && $urandom_range(99) < 14) @(negedge i_clk);
        pix.valid      = 1'b1;
        pix.gray       = g;
        pix.last_pixel = last;
        do @(posedge i_clk); while (!pix.ready);
        halftone_pixel(g, last, res);
        if (typed) pending_dots.push_back('{tdot, 1'b1, 1'b1});
        else foreach (res[i]) pending_dots.push_back(res[i]);
        pixels_sent++;
        if (last) images_sent++;
        @(negedge i_clk);
        pix.valid = 1'b0;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!cfg.ready);
        case (idx)
            REG_MAX_SIZE: ht_size   = value & 6'h3f;
            REG_EDGE_THR: ht_thr    = value & 13'h1fff;
            REG_PRECIP:   ht_precip = value & 1;
            REG_CLUST:    ht_clust  = value & 1;
            default: ;
        endcase
        @(negedge i_clk);
        cfg.valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_dots.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_image(input int len);
        int style, base, g;
        style = $urandom_range(3);
        base  = $urandom_range(255);
        for (int i = 0; i < len; i++) begin
            case (style)
                0: g = $urandom_range(255);
                1: begin
                    g = base + $urandom_range(16) - 8;
                    if (g < 0) g = 0;
                    if (g > 255) g = 255;
                end
                2: g = ($urandom_range(5) == 0) ? $urandom_range(1) * 255 : base;
                default: g = (i / ($urandom_range(3) + 2)) % 2 ? 255 - base : base;
            endcase
            send_pixel(g[7:0], i == len - 1, 0, 0);
        end
    endtask

    initial begin
        int settings [7][4];
        int budget;
        settings = '{'{3, 0, 1, 1}, '{32, 8191, 0, 1}, '{63, 50, 1, 0}, '{0, 200, 0, 0},
                     '{1, 10, 1, 1}, '{20, 1000, 1, 1}, '{0, 0, 0, 0}};
        cycles = 0; mismatches = 0; pixels_sent = 0; images_sent = 0;
        dots_seen = 0; phases_run = 0; quiet = 0;
        pix.valid = 0; pix.gray = 0; pix.last_pixel = 0;
        cfg.valid = 0; cfg.index = REG_MAX_SIZE; cfg.data = 0;
        dots.ready = 0;
        ht_size = 16; ht_thr = 128; ht_precip = 1; ht_clust = 1;
        ht_reset_image();
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i])
            send_pixel(dir_rows[i].gray, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].dot);
        send_image(12);

        for (int p = 0; p < 7; p++) begin
            drain();
            if (p == 6) begin
                settings[p] = '{$urandom_range(63), $urandom_range(8191),
                                $urandom_range(1), $urandom_range(1)};
            end
            write_reg(REG_MAX_SIZE, settings[p][0]);
            write_reg(REG_EDGE_THR, settings[p][1]);
            write_reg(REG_PRECIP, settings[p][2]);
            write_reg(REG_CLUST, settings[p][3]);
            quiet = (p == 2);
            phases_run++;
            budget = pixels_sent + 32;
            while (pixels_sent < budget)
                send_image(($urandom_range(4) == 0) ? $urandom_range(1, 6)
                                                    : $urandom_range(4, 40));
        end
        quiet = 0;

        drain();
        if (pending_dots.size() != 0) mismatches++;
        $display("covered %0d pixels in %0d images over %0d register settings",
                 pixels_sent, images_sent, phases_run + 1);
        $display("checked %0d dots, %0d mismatches", dots_seen, mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/scch_pkg.sv
design/scch_if.sv
design/scch_fifo.sv
design/scch_front.sv
design/scch_back.sv
design/space_curve_cluster_halftoner_top.sv
design/scch_checker.sv
sim/space_curve_cluster_halftoner_top_test.sv
